[rtl/ptl_pkg.sv]
// ----------------------------------------------------------------------------
// Pedestrian traffic light package
// Shared lamp bundle and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ptl_pkg;

	// Six lamp drives of one tick result, 1 = lamp on.
	typedef struct packed {
		logic car_green;
		logic car_yellow;
		logic car_red;
		logic walk_green;
		logic walk_yellow;
		logic walk_red;
	} lamps_t;

	// Configuration register indexes.
	localparam logic CFG_PHASE_TICKS      = 1'b0;
	localparam logic CFG_BLINK_HALF_TICKS = 1'b1;

	// Register reset values.
	localparam logic [15:0] PHASE_TICKS_RST      = 16'd5000;
	localparam logic [15:0] BLINK_HALF_TICKS_RST = 16'd250;

endpackage

`default_nettype wire

[rtl/ptl_ctrl.sv]
// ----------------------------------------------------------------------------
// Pedestrian traffic light sequencer
// Holds the phase state and counters, applies one tick per accepted item and
// decodes the lamps of the phase shown in that tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_ctrl import ptl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tick,
	input  wire logic        button_event,
	input  wire logic [15:0] phase_ticks,
	input  wire logic [15:0] blink_half_ticks,
	output lamps_t           lamps
);

	typedef enum logic [1:0] {
		CAR_GREEN  = 2'd0,
		CAR_YELLOW = 2'd1,
		CAR_RED    = 2'd2
	} car_phase_t;

	typedef enum logic [1:0] {
		WALK_NONE        = 2'd0,
		WALK_READY_CROSS = 2'd1,
		WALK_CROSS       = 2'd2,
		WALK_READY_STOP  = 2'd3
	} walk_phase_t;

	car_phase_t  car_q;
	walk_phase_t walk_q;
	logic        back_q;
	logic [15:0] phase_cnt_q;
	logic [15:0] blink_cnt_q;
	logic        blink_lvl_q;

	logic        press;
	walk_phase_t walk_b;
	logic [15:0] phase_cnt_b;
	logic [15:0] blink_cnt_b;
	logic        blink_lvl_b;
	logic [16:0] phase_cnt_inc;
	logic [16:0] blink_cnt_inc;
	logic        phase_end;
	logic        blink_end;

	// A press in normal mode starts the pedestrian sequence in this same tick.
	always_comb begin
		press       = button_event && (walk_q == WALK_NONE);
		walk_b      = walk_q;
		phase_cnt_b = phase_cnt_q;
		blink_cnt_b = blink_cnt_q;
		blink_lvl_b = blink_lvl_q;
		if (press) begin
			walk_b      = (car_q == CAR_RED) ? WALK_CROSS : WALK_READY_CROSS;
			phase_cnt_b = '0;
			blink_cnt_b = '0;
			blink_lvl_b = 1'b1;
		end
	end

	// End-of-period checks; a zero period ends every tick.
	assign phase_cnt_inc = {1'b0, phase_cnt_b} + 17'd1;
	assign blink_cnt_inc = {1'b0, blink_cnt_b} + 17'd1;
	assign phase_end     = phase_cnt_inc >= {1'b0, phase_ticks};
	assign blink_end     = blink_cnt_inc >= {1'b0, blink_half_ticks};

	// Lamp decode for the phase shown in this tick.
	always_comb begin
		lamps = '0;
		case (walk_b)
			WALK_READY_CROSS: begin
				lamps.car_yellow  = blink_lvl_b;
				lamps.walk_yellow = blink_lvl_b;
				lamps.walk_red    = 1'b1;
			end
			WALK_CROSS: begin
				lamps.car_red    = 1'b1;
				lamps.walk_green = 1'b1;
			end
			WALK_READY_STOP: begin
				lamps.walk_green  = 1'b1;
				lamps.car_yellow  = blink_lvl_b;
				lamps.walk_yellow = blink_lvl_b;
			end
			default: begin
				lamps.walk_red = 1'b1;
				case (car_q)
					CAR_YELLOW: lamps.car_yellow = blink_lvl_b;
					CAR_RED:    lamps.car_red    = 1'b1;
					default:    lamps.car_green  = 1'b1;
				endcase
			end
		endcase
	end

	// Phase state and counters advance once per accepted tick. A phase end
	// restarts both counters and the blink level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_q       <= CAR_GREEN;
			walk_q      <= WALK_NONE;
			back_q      <= 1'b0;
			phase_cnt_q <= '0;
			blink_cnt_q <= '0;
			blink_lvl_q <= 1'b1;
		end else if (tick) begin
			if (phase_end) begin
				phase_cnt_q <= '0;
				blink_cnt_q <= '0;
				blink_lvl_q <= 1'b1;
				case (walk_b)
					WALK_READY_CROSS: walk_q <= WALK_CROSS;
					WALK_CROSS:       walk_q <= WALK_READY_STOP;
					WALK_READY_STOP: begin
						walk_q <= WALK_NONE;
						car_q  <= CAR_GREEN;
						back_q <= 1'b0;
					end
					default: begin
						walk_q <= walk_b;
						case (car_q)
							CAR_YELLOW: car_q <= back_q ? CAR_GREEN : CAR_RED;
							CAR_RED: begin
								car_q  <= CAR_YELLOW;
								back_q <= 1'b1;
							end
							default: begin
								car_q  <= CAR_YELLOW;
								back_q <= 1'b0;
							end
						endcase
					end
				endcase
			end else begin
				walk_q      <= walk_b;
				phase_cnt_q <= phase_cnt_inc[15:0];
				if (blink_end) begin
					blink_cnt_q <= '0;
					blink_lvl_q <= ~blink_lvl_b;
				end else begin
					blink_cnt_q <= blink_cnt_inc[15:0];
					blink_lvl_q <= blink_lvl_b;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/ptl_out_skid.sv]
// ----------------------------------------------------------------------------
// Pedestrian traffic light result buffer
// Output register with one skid entry, so a new tick is taken while a result
// still waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module ptl_out_skid import ptl_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire lamps_t push_lamps,
	output logic        full,
	output logic        out_valid,
	input  wire logic   out_stall,
	output lamps_t      out_lamps
);

	logic   out_valid_q;
	logic   skid_valid_q;
	lamps_t out_lamps_q;
	lamps_t skid_lamps_q;
	logic   take;

	assign take      = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_lamps = out_lamps_q;

	// Control: the skid entry drains first; new results fill the output
	// register when it frees up, otherwise the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers follow the same transfers.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_lamps_q <= skid_lamps_q;
			end
		end else if (push) begin
			if (out_valid_q && !take) begin
				skid_lamps_q <= push_lamps;
			end else begin
				out_lamps_q <= push_lamps;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pedestrian_traffic_light_fsm.sv]
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller
// One input transfer is one time tick with the button flag; each tick yields
// one transfer of the six lamp drives.
//
//   Channel | Signals                               | Direction
//   --------+---------------------------------------+-----------
//   in      | in_valid, in_stall, button_event      | into block
//   out     | out_valid, out_stall, six lamp fields | out of block
//   cfg     | cfg_valid, cfg_ready, cfg_index/data  | into block
//
// A tick is accepted every cycle while in_stall is low; its lamps are
// registered in the output register, or in the skid entry ahead of it.
// Reset loads the default periods and starts normal green, going forward.
// in_stall rises only when both the output register and the skid entry hold
// results; configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pedestrian_traffic_light_fsm import ptl_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        button_event,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             car_green,
	output logic             car_yellow,
	output logic             car_red,
	output logic             walk_green,
	output logic             walk_yellow,
	output logic             walk_red
);

	logic [15:0] phase_ticks_q;
	logic [15:0] blink_half_ticks_q;
	logic        tick;
	logic        full;
	lamps_t      tick_lamps;
	lamps_t      out_lamps;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign tick      = in_valid && !full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q      <= PHASE_TICKS_RST;
			blink_half_ticks_q <= BLINK_HALF_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PHASE_TICKS:      phase_ticks_q      <= cfg_data;
				CFG_BLINK_HALF_TICKS: blink_half_ticks_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	// Phase sequencer.
	ptl_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick             (tick),
		.button_event     (button_event),
		.phase_ticks      (phase_ticks_q),
		.blink_half_ticks (blink_half_ticks_q),
		.lamps            (tick_lamps)
	);

	// Result buffer.
	ptl_out_skid u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (tick),
		.push_lamps (tick_lamps),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_lamps  (out_lamps)
	);

	assign car_green   = out_lamps.car_green;
	assign car_yellow  = out_lamps.car_yellow;
	assign car_red     = out_lamps.car_red;
	assign walk_green  = out_lamps.walk_green;
	assign walk_yellow = out_lamps.walk_yellow;
	assign walk_red    = out_lamps.walk_red;

endmodule

`default_nettype wire

[sim/ptl_lamp_checker.sv]
// ----------------------------------------------------------------------------
// Pedestrian traffic light lamp checker
// Watches the tick, result and configuration channels of the controller. For
// every accepted tick it predicts the six lamp drives from its own copy of the
// phase state and periods. It checks each result transfer against the oldest
// prediction, and hands the mismatch count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------

module ptl_lamp_checker import ptl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        button_event,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        car_green,
	input  logic        car_yellow,
	input  logic        car_red,
	input  logic        walk_green,
	input  logic        walk_yellow,
	input  logic        walk_red,
	output int          fail_count,
	output int          pending
);

	typedef enum logic [1:0] {
		CAR_GO    = 2'd0,
		CAR_AMBER = 2'd1,
		CAR_STOP  = 2'd2
	} car_state_t;

	typedef enum logic [1:0] {
		PED_IDLE        = 2'd0,
		PED_READY_CROSS = 2'd1,
		PED_CROSS       = 2'd2,
		PED_READY_STOP  = 2'd3
	} walk_state_t;

	// Predicted controller state and periods.
	car_state_t  car_state;
	walk_state_t walk_state;
	logic        backward;
	logic [15:0] phase_count;
	logic [15:0] blink_count;
	logic        blink_on;
	logic [15:0] phase_len;
	logic [15:0] blink_len;

	// Lamp drives still owed by the block, oldest first.
	lamps_t lamps_due[$];

	// Every phase starts with fresh counters and the blinking lamp on.
	task automatic restart_phase();
		phase_count = '0;
		blink_count = '0;
		blink_on    = 1'b1;
	endtask

	// Advances the predicted state by one tick and returns that tick's lamps.
	task automatic predict_lamps(input logic press, output lamps_t lamps);
		lamps = '0;

		// A press only counts while no pedestrian sequence is running.
		if (press && walk_state == PED_IDLE) begin
			walk_state = (car_state == CAR_STOP) ? PED_CROSS : PED_READY_CROSS;
			restart_phase();
		end

		case (walk_state)
			PED_READY_CROSS: begin
				lamps.car_yellow  = blink_on;
				lamps.walk_yellow = blink_on;
				lamps.walk_red    = 1'b1;
			end
			PED_CROSS: begin
				lamps.car_red    = 1'b1;
				lamps.walk_green = 1'b1;
			end
			PED_READY_STOP: begin
				lamps.walk_green  = 1'b1;
				lamps.car_yellow  = blink_on;
				lamps.walk_yellow = blink_on;
			end
			default: begin
				lamps.walk_red = 1'b1;
				case (car_state)
					CAR_AMBER: lamps.car_yellow = blink_on;
					CAR_STOP:  lamps.car_red    = 1'b1;
					default:   lamps.car_green  = 1'b1;
				endcase
			end
		endcase

		// A zero period acts as one, and a period lowered below the count
		// ends the half on this tick.
		if (int'(blink_count) + 1 >= int'(blink_len)) begin
			blink_count = '0;
			blink_on    = ~blink_on;
		end else begin
			blink_count = blink_count + 16'd1;
		end

		// Phase end: walk the pedestrian sequence or the normal cycle.
		if (int'(phase_count) + 1 >= int'(phase_len)) begin
			case (walk_state)
				PED_READY_CROSS: walk_state = PED_CROSS;
				PED_CROSS:       walk_state = PED_READY_STOP;
				PED_READY_STOP: begin
					walk_state = PED_IDLE;
					car_state  = CAR_GO;
					backward   = 1'b0;
				end
				default: begin
					if (car_state == CAR_AMBER) begin
						car_state = backward ? CAR_GO : CAR_STOP;
					end else if (car_state == CAR_STOP) begin
						car_state = CAR_AMBER;
						backward  = 1'b1;
					end else begin
						car_state = CAR_AMBER;
						backward  = 1'b0;
					end
				end
			endcase
			restart_phase();
		end else begin
			phase_count = phase_count + 16'd1;
		end
	endtask

	// Reports one lamp that differs from its prediction.
	function automatic int lamp_differs(string name, logic want_bit, logic got_bit);
		if (want_bit !== got_bit) begin
			$error("%s: expected %0b, actual %0b", name, want_bit, got_bit);
			return 1;
		end
		return 0;
	endfunction

	// Channel monitor. The result transfer is handled first, since it always
	// belongs to a tick accepted at an earlier edge.
	always @(posedge clk or negedge arst_n) begin
		lamps_t want;
		lamps_t next_lamps;
		int     wrong;

		if (!arst_n) begin
			car_state   = CAR_GO;
			walk_state  = PED_IDLE;
			backward    = 1'b0;
			phase_count = '0;
			blink_count = '0;
			blink_on    = 1'b1;
			phase_len   = PHASE_TICKS_RST;
			blink_len   = BLINK_HALF_TICKS_RST;
			lamps_due.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (lamps_due.size() == 0) begin
					$error("lamp transfer with no tick outstanding");
					fail_count++;
				end else begin
					want  = lamps_due.pop_front();
					wrong = lamp_differs("car_green", want.car_green, car_green)
					      + lamp_differs("car_yellow", want.car_yellow, car_yellow)
					      + lamp_differs("car_red", want.car_red, car_red)
					      + lamp_differs("walk_green", want.walk_green, walk_green)
					      + lamp_differs("walk_yellow", want.walk_yellow, walk_yellow)
					      + lamp_differs("walk_red", want.walk_red, walk_red);
					if (wrong != 0) begin
						fail_count++;
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PHASE_TICKS:      phase_len = cfg_data;
					CFG_BLINK_HALF_TICKS: blink_len = cfg_data;
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				predict_lamps(button_event, next_lamps);
				lamps_due.push_back(next_lamps);
			end

			pending = lamps_due.size();
		end
	end

endmodule

[sim/pedestrian_traffic_light_fsm_tb.sv]
// ----------------------------------------------------------------------------
// Pedestrian traffic light controller testbench
// Drives button ticks and period writes into the controller, with random gaps
// on the tick side and random stalls on the lamp side. A directed opening walks
// every press situation and the period extremes, then random segments run with
// short random periods. The lamp checker predicts and compares; this module
// makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------

module pedestrian_traffic_light_fsm_tb;
	import ptl_pkg::*;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic        button_event = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic        cfg_index    = CFG_PHASE_TICKS;
	logic [15:0] cfg_data     = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic        car_green;
	logic        car_yellow;
	logic        car_red;
	logic        walk_green;
	logic        walk_yellow;
	logic        walk_red;

	int fail_count;
	int pending;

	// Percent of cycles in which the tick side holds back or the lamp side stalls.
	int send_idle_pct  = 30;
	int recv_stall_pct = 87;

	pedestrian_traffic_light_fsm u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.button_event(button_event),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.car_green   (car_green),
		.car_yellow  (car_yellow),
		.car_red     (car_red),
		.walk_green  (walk_green),
		.walk_yellow (walk_yellow),
		.walk_red    (walk_red)
	);

	ptl_lamp_checker u_lamp_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.button_event(button_event),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.car_green   (car_green),
		.car_yellow  (car_yellow),
		.car_red     (car_red),
		.walk_green  (walk_green),
		.walk_yellow (walk_yellow),
		.walk_red    (walk_red),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Free-running clock.
	initial begin
		forever #6 clk = ~clk;
	end

	// Random stalls on the lamp side.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Hard stop in case the block hangs.
	initial begin
		#(12 * 200000);
		$display("Test completed with failures");
		$finish;
	end

	// Offers one tick after a random gap and holds it until the transfer.
	task automatic send_tick(input logic press);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid     = 1'b1;
		button_event = press;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stops offering ticks and waits until every lamp transfer has come back.
	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
	endtask

	// Writes one period register while the block is idle.
	task automatic write_reg(input logic idx, input logic [15:0] value);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Sends a fixed press pattern, oldest tick in the lowest bit.
	task automatic send_pattern(input int count, input logic [15:0] presses);
		for (int i = 0; i < count; i++) begin
			send_tick(presses[i]);
		end
	endtask

	initial begin
		logic [15:0] phase_value;
		logic [15:0] blink_value;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default periods: a press on green starts ready-cross, a second
		// press inside the sequence is ignored.
		send_pattern(4, 16'b1100);

		// Zero periods end every phase each tick: the sequence runs out to
		// green, then a press on red and a press on yellow.
		write_reg(CFG_PHASE_TICKS, 16'd0);
		write_reg(CFG_BLINK_HALF_TICKS, 16'd0);
		send_pattern(9, 16'b1_0010_0000);

		// Longest periods, then both lowered below the running counts.
		write_reg(CFG_PHASE_TICKS, 16'hFFFF);
		write_reg(CFG_BLINK_HALF_TICKS, 16'hFFFF);
		send_pattern(4, 16'b0001);
		write_reg(CFG_PHASE_TICKS, 16'd2);
		write_reg(CFG_BLINK_HALF_TICKS, 16'd1);
		send_pattern(4, 16'b0000);

		// Three idling regimes; each segment sets a new phase period, some a new blink.
		for (int stage = 0; stage < 3; stage++) begin
			case (stage)
				0: begin
					send_idle_pct  = 30;
					recv_stall_pct = 87;
				end
				1: begin
					send_idle_pct  = 87;
					recv_stall_pct = 30;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 7; seg++) begin
				case ($urandom_range(19))
					0:       phase_value = 16'hFFFF;
					1, 2:    phase_value = 16'($urandom_range(9, 40));
					default: phase_value = 16'($urandom_range(0, 8));
				endcase
				case ($urandom_range(19))
					0:       blink_value = 16'hFFFF;
					default: blink_value = 16'($urandom_range(0, 4));
				endcase
				write_reg(CFG_PHASE_TICKS, phase_value);
				if ($urandom_range(1) == 1) begin
					write_reg(CFG_BLINK_HALF_TICKS, blink_value);
				end
				for (int k = 0; k < 31; k++) begin
					send_tick($urandom_range(99) < 15);
				end
			end
		end

		// Let the last lamp transfers arrive, then a short settling time.
		drain();
		repeat (10) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
